>>> src/tbslc_pkg.sv
package tbslc_pkg;

	// request codes on the input tuser
	typedef enum logic [1:0] {
		REQ_SEND = 2'd0,
		REQ_LINE = 2'd1,
		REQ_POLL = 2'd2
	} req_type_t;

	// result codes on the output tuser
	typedef enum logic [1:0] {
		OK_LINE    = 2'd0,
		OK_CHAR    = 2'd1,
		OK_DONE    = 2'd2,
		OK_TIMEOUT = 2'd3
	} out_kind_t;

	localparam logic [7:0]  CH_CR         = 8'h0D;
	localparam logic [7:0]  CH_LF         = 8'h0A;
	localparam logic [7:0]  FILL_BYTE     = 8'hDB;
	localparam logic [15:0] TIMEOUT_RESET = 16'd500;
	localparam logic [15:0] POLL_MAX      = 16'hFFFF;
	localparam int          MAX_RESULTS   = 12;
	localparam int          CNT_W         = $clog2(MAX_RESULTS + 1);

	// register select (paddr bit 2)
	localparam logic REG_TIMEOUT = 1'b0;

	// one result word
	typedef struct packed {
		out_kind_t  kind;
		logic [7:0] data;
		logic       conn;
	} res_word_t;

	// all results caused by one item
	typedef struct packed {
		logic [CNT_W-1:0]                  count;
		res_word_t [MAX_RESULTS-1:0]       words;
	} res_list_t;

	// line byte carrying one bit pair of a character
	function automatic logic [7:0] spread_byte(input logic [7:0] c, input logic [1:0] pair);
		logic [7:0] b;
		b    = FILL_BYTE;
		b[2] = c[{pair, 1'b0}];
		b[5] = c[{pair, 1'b1}];
		return b;
	endfunction

endpackage

>>> src/tbslc_core.sv
module tbslc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [1:0]           req_type,
	input  logic [7:0]           data_byte,
	input  logic                 end_of_command,
	input  logic [15:0]          timeout_limit,
	output tbslc_pkg::res_list_t list
);

	logic       recv_q, link_q;
	logic [1:0] pos_q;
	logic [7:0] partial_q;
	logic [2:0] cs_q;
	logic [15:0] poll_q;
	logic [2:0][7:0] held_q;

	logic       n_recv, n_link;
	logic [1:0] n_pos;
	logic [7:0] n_partial;
	logic [2:0] n_cs;
	logic [15:0] n_poll;
	logic [2:0][7:0] n_held;

	logic [7:0] new_partial;
	logic       is_send;
	logic [tbslc_pkg::CNT_W-1:0] cnt;
	tbslc_pkg::res_word_t w0, w1;
	tbslc_pkg::res_word_t [tbslc_pkg::MAX_RESULTS-1:0] send_w;
	logic [2:0][7:0] chr;
	logic       prev_cr, is_lf, timed_out;

	// send side: command char then cr, lf
	assign chr = {tbslc_pkg::CH_LF, tbslc_pkg::CH_CR, data_byte};

	for (genvar g = 0; g < tbslc_pkg::MAX_RESULTS; g++) begin : g_send
		assign send_w[g] = '{kind: tbslc_pkg::OK_LINE,
			data: tbslc_pkg::spread_byte(chr[g / 4], 2'(g % 4)), conn: link_q};
	end

	// bit pair from the line byte into the partial character
	always_comb begin
		new_partial = partial_q;
		unique case (pos_q)
			2'd0: new_partial[1:0] = {data_byte[5], data_byte[2]};
			2'd1: new_partial[3:2] = {data_byte[5], data_byte[2]};
			2'd2: new_partial[5:4] = {data_byte[5], data_byte[2]};
			2'd3: new_partial[7:6] = {data_byte[5], data_byte[2]};
			default: new_partial = partial_q;
		endcase
	end

	assign is_lf     = (new_partial == tbslc_pkg::CH_LF);
	assign prev_cr   = (cs_q == 3'd1) ? (held_q[0] == tbslc_pkg::CH_CR)
		: (held_q[1] == tbslc_pkg::CH_CR);
	assign timed_out = poll_q > timeout_limit;

	// next state and result words
	always_comb begin
		n_recv    = recv_q;
		n_link    = link_q;
		n_pos     = pos_q;
		n_partial = partial_q;
		n_cs      = cs_q;
		n_poll    = poll_q;
		n_held    = held_q;
		cnt       = '0;
		is_send   = 1'b0;
		w0        = '{kind: tbslc_pkg::OK_DONE, data: 8'd0, conn: 1'b1};
		w1        = '{kind: tbslc_pkg::OK_DONE, data: 8'd0, conn: 1'b1};
		unique case (tbslc_pkg::req_type_t'(req_type))
			tbslc_pkg::REQ_SEND: begin
				is_send = 1'b1;
				n_recv  = end_of_command;
				cnt     = end_of_command ? tbslc_pkg::CNT_W'(12) : tbslc_pkg::CNT_W'(4);
				if (end_of_command) begin
					n_pos     = 2'd0;
					n_partial = 8'd0;
					n_cs      = 3'd0;
					n_poll    = 16'd0;
				end
			end
			tbslc_pkg::REQ_LINE, tbslc_pkg::REQ_POLL: begin
				if (recv_q) begin
					if (timed_out) begin
						n_recv = 1'b0;
						n_link = 1'b0;
						w0     = '{kind: tbslc_pkg::OK_TIMEOUT, data: 8'd0, conn: 1'b0};
						cnt    = tbslc_pkg::CNT_W'(1);
					end else begin
						if (poll_q != tbslc_pkg::POLL_MAX)
							n_poll = poll_q + 16'd1;
						if (req_type == tbslc_pkg::REQ_LINE) begin
							n_partial = new_partial;
							n_pos     = pos_q + 2'd1;
							if (pos_q == 2'd3) begin
								// a whole character is in
								priority if (cs_q < 3'd3) begin
									n_held[cs_q[1:0]] = new_partial;
									n_cs = cs_q + 3'd1;
									if (cs_q != 3'd0 && prev_cr && is_lf) begin
										n_recv = 1'b0;
										n_link = 1'b1;
										if (cs_q == 3'd2) begin
											w0  = '{kind: tbslc_pkg::OK_CHAR,
												data: held_q[0], conn: link_q};
											cnt = tbslc_pkg::CNT_W'(2);
										end else begin
											cnt = tbslc_pkg::CNT_W'(1);
										end
									end
								end else if (cs_q == 3'd3) begin
									if (held_q[2] == tbslc_pkg::CH_CR && is_lf) begin
										n_recv = 1'b0;
										n_link = 1'b1;
										cnt    = tbslc_pkg::CNT_W'(1);
									end else begin
										n_held[0] = new_partial;
										n_cs      = 3'd4;
									end
								end else begin
									if (held_q[0] == tbslc_pkg::CH_CR && is_lf) begin
										n_recv = 1'b0;
										n_link = 1'b1;
										cnt    = tbslc_pkg::CNT_W'(1);
									end else begin
										// stream the delayed character
										w0 = '{kind: tbslc_pkg::OK_CHAR,
											data: held_q[0], conn: link_q};
										n_held[0] = new_partial;
										cnt = tbslc_pkg::CNT_W'(1);
									end
								end
							end
						end
					end
				end
			end
			default: cnt = '0;
		endcase
	end

	// result list
	always_comb begin
		list.count = cnt;
		list.words = send_w;
		if (!is_send) begin
			list.words[0] = w0;
			list.words[1] = w1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q    <= 1'b0;
			link_q    <= 1'b0;
			pos_q     <= 2'd0;
			partial_q <= 8'd0;
			cs_q      <= 3'd0;
			poll_q    <= 16'd0;
		end else if (step) begin
			recv_q    <= n_recv;
			link_q    <= n_link;
			pos_q     <= n_pos;
			partial_q <= n_partial;
			cs_q      <= n_cs;
			poll_q    <= n_poll;
		end
	end

	// held characters, no reset
	always_ff @(posedge clk) begin
		if (step)
			held_q <= n_held;
	end

	// character count saturates at four
	a_cs_range: assert property (@(posedge clk) disable iff (!arst_n) cs_q <= 3'd4)
		else $error("character count out of range");

	// a timeout drops both receive and link
	a_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		step && recv_q && timed_out &&
		(req_type == tbslc_pkg::REQ_LINE || req_type == tbslc_pkg::REQ_POLL)
		|=> !recv_q && !link_q)
		else $error("timeout left link state set");

	// completion brings the link up and ends receive
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && !is_send && cnt != '0 && w1.kind == tbslc_pkg::OK_DONE &&
		((cnt == tbslc_pkg::CNT_W'(2)) || (w0.kind == tbslc_pkg::OK_DONE))
		|=> link_q && !recv_q)
		else $error("completion did not raise link");

endmodule

>>> src/two_bit_spread_line_codec_unit.sv
// an accepted word is registered, its results then go to the result register
// throughput: one input word per cycle while m_tready is high and each word yields
// at most one result; a word with n results holds the result register until all are
// taken (4 or 12 for a send); the next input word is taken with the last of them
// reset: arst_n clears all control state and loads timeout_limit with 500
// results are unaffected by stalls on either side
module two_bit_spread_line_codec_unit (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte
	input  logic [1:0]  s_tuser,  // req_type
	input  logic        s_tlast,  // end_of_command
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // out_byte [7:0], connected [8], zero fill
	output logic [1:0]  m_tuser,  // out_kind
	output logic        m_tlast   // last
);

	logic [15:0] limit_q;
	logic        v_s1, eoc_s1;
	logic [1:0]  type_s1;
	logic [7:0]  data_s1;
	logic        busy_q;
	logic [tbslc_pkg::CNT_W-1:0] cnt_q, idx_q;
	tbslc_pkg::res_word_t [tbslc_pkg::MAX_RESULTS-1:0] words_q;
	tbslc_pkg::res_list_t list;
	tbslc_pkg::res_word_t cur;
	logic        is_last, last_take, advance;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == tbslc_pkg::REG_TIMEOUT) ? {16'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= tbslc_pkg::TIMEOUT_RESET;
		else if (psel && penable && pwrite && paddr[2] == tbslc_pkg::REG_TIMEOUT)
			limit_q <= pwdata[15:0];
	end

	// handshake between input register and result register
	assign is_last   = (idx_q == cnt_q - tbslc_pkg::CNT_W'(1));
	assign last_take = busy_q && m_tready && is_last;
	assign advance   = v_s1 && (!busy_q || last_take);
	assign s_tready  = !v_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s_tvalid && s_tready)
			v_s1 <= 1'b1;
		else if (advance)
			v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			type_s1 <= s_tuser;
			data_s1 <= s_tdata;
			eoc_s1  <= s_tlast;
		end
	end

	tbslc_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.req_type       (type_s1),
		.data_byte      (data_s1),
		.end_of_command (eoc_s1),
		.timeout_limit  (limit_q),
		.list           (list)
	);

	// result register and word index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else if (advance) begin
			busy_q <= (list.count != '0);
			cnt_q  <= list.count;
			idx_q  <= '0;
		end else if (busy_q && m_tready) begin
			if (is_last)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + tbslc_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			words_q <= list.words;
	end

	// output word
	assign cur      = words_q[idx_q];
	assign m_tvalid = busy_q;
	assign m_tuser  = cur.kind;
	assign m_tdata  = {7'd0, cur.conn, cur.data};
	assign m_tlast  = is_last;

	// shown word always lies within the loaded list
	a_idx: assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> idx_q < cnt_q)
		else $error("result index beyond count");

endmodule
